// ===== sv/gsel_pkg.sv =====
// Shared constants, codes and types of the gated target selector.
package gsel_pkg;

	// Field widths of the ports
	localparam int POS_W   = 16;
	localparam int VEL_W   = 16;
	localparam int ID_W    = 32;
	localparam int AGE_W   = 16;
	localparam int OP_W    = 2;
	localparam int SPEED_W = 17;

	// Configuration registers
	localparam int GATE_W     = 15;
	localparam int HEIGHT_W   = 16;
	localparam int MINSPD_W   = 17;
	localparam int STALE_W    = 16;
	localparam int GATE_SQ_W  = 2 * GATE_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_GATE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MINSPD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STALE  = 2'd3;

	localparam logic [GATE_W-1:0]   GATE_RST   = 15'd2500;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd125;
	localparam logic [MINSPD_W-1:0] MINSPD_RST = 17'd10;
	localparam logic [STALE_W-1:0]  STALE_RST  = 16'd1000;

	// Item operation codes
	localparam logic [OP_W-1:0] OP_REF  = 2'd0;
	localparam logic [OP_W-1:0] OP_CAND = 2'd1;
	localparam logic [OP_W-1:0] OP_END  = 2'd2;

	// Default coordinate width and queue depth (power of two)
	localparam int COORD_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== sv/gsel_fifo.sv =====
// Short queue of classified items between the front and back parts.
module gsel_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output gsel_pkg::q_stat_t stat
);
	import gsel_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      cnt_q;

	assign stat.full  = (cnt_q == (AW+1)'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== sv/gsel_front.sv =====
// Front part: accepts items, gates candidates by distance and height.
module gsel_front #(
	parameter int COORD_BITS = gsel_pkg::COORD_BITS_DEF,
	parameter int ENTRY_W    = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [gsel_pkg::OP_W-1:0]           op,
	input  logic signed [gsel_pkg::POS_W-1:0]   pos_x,
	input  logic signed [gsel_pkg::POS_W-1:0]   pos_y,
	input  logic signed [gsel_pkg::POS_W-1:0]   pos_z,
	input  logic signed [gsel_pkg::VEL_W-1:0]   vel_x,
	input  logic signed [gsel_pkg::VEL_W-1:0]   vel_y,
	input  logic signed [gsel_pkg::VEL_W-1:0]   vel_z,
	input  logic [gsel_pkg::ID_W-1:0]           track_id,
	input  logic [gsel_pkg::AGE_W-1:0]          age,
	input  logic [gsel_pkg::GATE_W-1:0]         gate_distance,
	input  logic signed [gsel_pkg::HEIGHT_W-1:0] height_limit,
	input  gsel_pkg::q_stat_t                   q_stat,
	output logic                                q_push,
	output logic [ENTRY_W-1:0]                  q_wdata
);
	import gsel_pkg::*;

	// A coordinate wider than the port is the port value zero-extended.
	localparam int CoordW = (COORD_BITS > POS_W) ? POS_W + 1 : COORD_BITS;
	localparam int SqW    = 2 * CoordW;
	localparam int DistW  = SqW + 2;
	localparam int CmpDW  = (DistW > GATE_SQ_W) ? DistW : GATE_SQ_W;
	localparam int HgtW   = POS_W + 2;

	function automatic logic signed [CoordW-1:0] to_coord(input logic [POS_W-1:0] v);
		logic [2*POS_W-1:0] w;
		w = {{POS_W{1'b0}}, v};
		return w[CoordW-1:0];
	endfunction

	function automatic logic [SPEED_W-1:0] vel_mag(input logic [VEL_W-1:0] v);
		return v[VEL_W-1] ? (SPEED_W'(0) - {1'b1, v}) : {1'b0, v};
	endfunction

	function automatic logic [CoordW-1:0] diff_mag(input logic signed [CoordW-1:0] a,
	                                               input logic signed [CoordW-1:0] b);
		logic signed [CoordW:0] d;
		logic [CoordW:0] m;
		d = {a[CoordW-1], a} - {b[CoordW-1], b};
		m = d[CoordW] ? ((CoordW+1)'(0) - d) : d;
		return m[CoordW-1:0];
	endfunction

	logic signed [CoordW-1:0] ref_x_q, ref_y_q, ref_z_q;
	logic [GATE_SQ_W-1:0]     gate_sq_q;

	logic signed [CoordW-1:0] cx, cy, cz;
	logic                     op_known, accept, stall;

	// Stage 1: differences, speed, height check
	logic                     valid_s1;
	logic [OP_W-1:0]          op_s1;
	logic signed [CoordW-1:0] px_s1, py_s1, pz_s1;
	logic [CoordW-1:0]        mx_s1, my_s1, mz_s1;
	logic [SPEED_W-1:0]       speed_s1;
	logic                     tall_s1;
	logic [ID_W-1:0]          id_s1;
	logic [AGE_W-1:0]         age_s1;

	// Stage 2: squares
	logic                     valid_s2;
	logic [OP_W-1:0]          op_s2;
	logic signed [CoordW-1:0] px_s2, py_s2, pz_s2;
	logic [SqW-1:0]           sx_s2, sy_s2, sz_s2;
	logic [SPEED_W-1:0]       speed_s2;
	logic                     tall_s2;
	logic [ID_W-1:0]          id_s2;
	logic [AGE_W-1:0]         age_s2;

	logic [DistW-1:0]         dist_sum;
	logic                     inside_gate;
	logic                     keep;

	assign cx = to_coord(pos_x);
	assign cy = to_coord(pos_y);
	assign cz = to_coord(pos_z);

	assign op_known = (op == OP_REF) || (op == OP_CAND) || (op == OP_END);
	assign stall    = valid_s2 && q_stat.full;
	assign in_ready = !stall;
	assign accept   = in_valid && in_ready;

	assign dist_sum = DistW'(sx_s2) + DistW'(sy_s2) + DistW'(sz_s2);
	assign inside_gate = (CmpDW'(dist_sum) <= CmpDW'(gate_sq_q)) && !tall_s2;
	assign keep = (op_s2 == OP_REF) || (op_s2 == OP_END) || ((op_s2 == OP_CAND) && inside_gate);
	assign q_push  = valid_s2 && !q_stat.full && keep;
	assign q_wdata = {op_s2, px_s2, py_s2, pz_s2, id_s2, age_s2, speed_s2, dist_sum};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ref_x_q  <= '0;
			ref_y_q  <= '0;
			ref_z_q  <= '0;
		end else begin
			if (!stall) begin
				valid_s1 <= in_valid && op_known;
				valid_s2 <= valid_s1;
			end
			// A reference item moves the reference for all later candidates
			if (accept && (op == OP_REF)) begin
				ref_x_q <= cx;
				ref_y_q <= cy;
				ref_z_q <= cz;
			end
		end
	end

	always_ff @(posedge clk) begin
		gate_sq_q <= GATE_SQ_W'(gate_distance) * GATE_SQ_W'(gate_distance);
		if (!stall) begin
			op_s1    <= op;
			px_s1    <= cx;
			py_s1    <= cy;
			pz_s1    <= cz;
			mx_s1    <= diff_mag(cx, ref_x_q);
			my_s1    <= diff_mag(cy, ref_y_q);
			mz_s1    <= diff_mag(cz, ref_z_q);
			speed_s1 <= vel_mag(vel_x) + vel_mag(vel_y) + vel_mag(vel_z);
			tall_s1  <= $signed({{(HgtW-CoordW){cz[CoordW-1]}}, cz})
			            > $signed({{(HgtW-HEIGHT_W){height_limit[HEIGHT_W-1]}}, height_limit});
			id_s1    <= track_id;
			age_s1   <= age;

			op_s2    <= op_s1;
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			pz_s2    <= pz_s1;
			sx_s2    <= SqW'(mx_s1) * SqW'(mx_s1);
			sy_s2    <= SqW'(my_s1) * SqW'(my_s1);
			sz_s2    <= SqW'(mz_s1) * SqW'(mz_s1);
			speed_s2 <= speed_s1;
			tall_s2  <= tall_s1;
			id_s2    <= id_s1;
			age_s2   <= age_s1;
		end
	end

endmodule

// ===== sv/gsel_back.sv =====
// Back part: keeps per-frame bests and emits the choice at end of frame.
module gsel_back #(
	parameter int COORD_BITS = gsel_pkg::COORD_BITS_DEF,
	parameter int ENTRY_W    = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gsel_pkg::q_stat_t                 q_stat,
	input  logic [ENTRY_W-1:0]                q_rdata,
	output logic                              q_pop,
	input  logic [gsel_pkg::MINSPD_W-1:0]     min_speed,
	input  logic [gsel_pkg::STALE_W-1:0]      stale_limit,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              known,
	output logic signed [gsel_pkg::POS_W-1:0] out_x,
	output logic signed [gsel_pkg::POS_W-1:0] out_y,
	output logic signed [gsel_pkg::POS_W-1:0] out_z,
	output logic [gsel_pkg::ID_W-1:0]         out_id,
	output logic [gsel_pkg::AGE_W-1:0]        out_age,
	output logic                              stale
);
	import gsel_pkg::*;

	localparam int CoordW = (COORD_BITS > POS_W) ? POS_W + 1 : COORD_BITS;
	localparam int DistW  = 2 * CoordW + 2;
	localparam int ExtW   = CoordW + POS_W;
	localparam int Slots  = 4;

	localparam logic [1:0] SLOT_FIRST = 2'd0;
	localparam logic [1:0] SLOT_MATCH = 2'd1;
	localparam logic [1:0] SLOT_FAST  = 2'd2;
	localparam logic [1:0] SLOT_NEAR  = 2'd3;

	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_MANY = 2'd2;

	logic [OP_W-1:0]          e_op;
	logic signed [CoordW-1:0] e_x, e_y, e_z;
	logic [ID_W-1:0]          e_id;
	logic [AGE_W-1:0]         e_age;
	logic [SPEED_W-1:0]       e_speed;
	logic [DistW-1:0]         e_dist;

	logic [1:0]               cnt_q;
	logic                     match_q;
	logic [SPEED_W-1:0]       best_speed_q;
	logic [DistW-1:0]         best_dist_q;
	logic [ID_W-1:0]          last_id_q;

	logic signed [CoordW-1:0] held_x_q [Slots];
	logic signed [CoordW-1:0] held_y_q [Slots];
	logic signed [CoordW-1:0] held_z_q [Slots];
	logic [ID_W-1:0]          held_id_q [Slots];
	logic [AGE_W-1:0]         held_age_q [Slots];

	logic                     out_valid_q, known_q, stale_q;
	logic signed [POS_W-1:0]  out_x_q, out_y_q, out_z_q;
	logic [ID_W-1:0]          out_id_q;
	logic [AGE_W-1:0]         out_age_q;

	logic                     out_free, is_cand, is_ref, is_end, first, id_hit, chosen;
	logic [Slots-1:0]         wr_slot;
	logic [1:0]               pick;
	logic signed [ExtW-1:0]   sel_x, sel_y, sel_z;

	assign {e_op, e_x, e_y, e_z, e_id, e_age, e_speed, e_dist} = q_rdata;

	// End of frame waits for the output register; everything else retires at once
	assign out_free = !out_valid_q || out_ready;
	assign q_pop    = !q_stat.empty && ((e_op != OP_END) || out_free);
	assign is_cand  = q_pop && (e_op == OP_CAND);
	assign is_ref   = q_pop && (e_op == OP_REF);
	assign is_end   = q_pop && (e_op == OP_END);

	assign first  = (cnt_q == CNT_NONE);
	assign id_hit = (e_id == last_id_q);
	assign chosen = (cnt_q != CNT_NONE);

	always_comb begin
		wr_slot             = '0;
		wr_slot[SLOT_FIRST] = is_cand && first;
		wr_slot[SLOT_MATCH] = is_cand && id_hit && (first || !match_q);
		wr_slot[SLOT_FAST]  = is_cand && (first || (e_speed > best_speed_q));
		wr_slot[SLOT_NEAR]  = is_cand && (first || (e_dist < best_dist_q));
	end

	always_comb begin
		if (cnt_q == CNT_ONE) begin
			pick = SLOT_FIRST;
		end else if (match_q) begin
			pick = SLOT_MATCH;
		end else if (best_speed_q >= min_speed) begin
			pick = SLOT_FAST;
		end else begin
			pick = SLOT_NEAR;
		end
	end

	assign sel_x = {{POS_W{held_x_q[pick][CoordW-1]}}, held_x_q[pick]};
	assign sel_y = {{POS_W{held_y_q[pick][CoordW-1]}}, held_y_q[pick]};
	assign sel_z = {{POS_W{held_z_q[pick][CoordW-1]}}, held_z_q[pick]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= CNT_NONE;
			match_q      <= 1'b0;
			best_speed_q <= '0;
			best_dist_q  <= '0;
			last_id_q    <= '1;
			out_valid_q  <= 1'b0;
		end else begin
			if (is_cand) begin
				cnt_q <= first ? CNT_ONE : CNT_MANY;
				if (wr_slot[SLOT_MATCH]) begin
					match_q <= 1'b1;
				end
				if (wr_slot[SLOT_FAST]) begin
					best_speed_q <= e_speed;
				end
				if (wr_slot[SLOT_NEAR]) begin
					best_dist_q <= e_dist;
				end
			end else if (is_ref || is_end) begin
				cnt_q        <= CNT_NONE;
				match_q      <= 1'b0;
				best_speed_q <= '0;
				best_dist_q  <= '0;
				if (is_end && chosen) begin
					last_id_q <= held_id_q[pick];
				end
			end
			if (is_end) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < Slots; s++) begin
			if (wr_slot[s]) begin
				held_x_q[s]   <= e_x;
				held_y_q[s]   <= e_y;
				held_z_q[s]   <= e_z;
				held_id_q[s]  <= e_id;
				held_age_q[s] <= e_age;
			end
		end
		if (is_end) begin
			known_q   <= chosen;
			out_x_q   <= chosen ? sel_x[POS_W-1:0] : '0;
			out_y_q   <= chosen ? sel_y[POS_W-1:0] : '0;
			out_z_q   <= chosen ? sel_z[POS_W-1:0] : '0;
			out_id_q  <= chosen ? held_id_q[pick] : '0;
			out_age_q <= chosen ? held_age_q[pick] : '0;
			stale_q   <= chosen && (held_age_q[pick] > stale_limit);
		end
	end

	assign out_valid = out_valid_q;
	assign known     = known_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;
	assign out_id    = out_id_q;
	assign out_age   = out_age_q;
	assign stale     = stale_q;

endmodule

// ===== sv/gated_target_selector_unit.sv =====
// Top level of the gated target selector: configuration, front, queue, back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transaction: op selects
//   a reference position that opens a frame, a candidate detection, or end of frame.
//   Unused op code 3 is dropped at the input and has no effect.
//   Output channel (out_valid/out_ready) carries one result per end-of-frame item:
//   the chosen candidate with known=1 and its stale flag, or known=0 and zeros.
//   Configuration: cfg_we writes cfg_data into register cfg_idx (0 gate distance,
//   1 height limit, 2 min speed, 3 stale limit) in the same cycle; write only while
//   the block is idle.
// Timing:
//   One item per cycle sustained while in_ready stays high. An end-of-frame transaction
//   passes two front stages (distance differences, then squares), the queue and the
//   back register stage before its result shows.
//   The front gates candidates; the back retires one queued item per cycle, an end-of-frame
//   item only once the output register is free, and updates the running bests in that cycle.
// Reset (arst_n low): registers take their defaults, the remembered id becomes all
//   ones, the reference becomes zero and the pipeline and queue are emptied.
// Back pressure: when out_ready is low the result holds in the output register;
//   the queue fills and then in_ready drops until the back can drain it.
module gated_target_selector_unit #(
	parameter int COORD_BITS  = gsel_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = gsel_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gsel_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [gsel_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [gsel_pkg::OP_W-1:0]           op,
	input  logic signed [gsel_pkg::POS_W-1:0]   pos_x,
	input  logic signed [gsel_pkg::POS_W-1:0]   pos_y,
	input  logic signed [gsel_pkg::POS_W-1:0]   pos_z,
	input  logic signed [gsel_pkg::VEL_W-1:0]   vel_x,
	input  logic signed [gsel_pkg::VEL_W-1:0]   vel_y,
	input  logic signed [gsel_pkg::VEL_W-1:0]   vel_z,
	input  logic [gsel_pkg::ID_W-1:0]           track_id,
	input  logic [gsel_pkg::AGE_W-1:0]          age,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                known,
	output logic signed [gsel_pkg::POS_W-1:0]   out_x,
	output logic signed [gsel_pkg::POS_W-1:0]   out_y,
	output logic signed [gsel_pkg::POS_W-1:0]   out_z,
	output logic [gsel_pkg::ID_W-1:0]           out_id,
	output logic [gsel_pkg::AGE_W-1:0]          out_age,
	output logic                                stale
);
	import gsel_pkg::*;

	// Queue entry: op, position, id, age, speed sum and squared distance
	localparam int CoordW  = (COORD_BITS > POS_W) ? POS_W + 1 : COORD_BITS;
	localparam int DistW   = 2 * CoordW + 2;
	localparam int EntryW  = OP_W + 3 * CoordW + ID_W + AGE_W + SPEED_W + DistW;

	logic [GATE_W-1:0]          gate_q;
	logic signed [HEIGHT_W-1:0] height_q;
	logic [MINSPD_W-1:0]        minspd_q;
	logic [STALE_W-1:0]         stale_lim_q;

	q_stat_t                    q_stat;
	logic                       q_push, q_pop;
	logic [EntryW-1:0]          q_wdata, q_rdata;

	// Configuration registers: write on enable, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q      <= GATE_RST;
			height_q    <= HEIGHT_RST;
			minspd_q    <= MINSPD_RST;
			stale_lim_q <= STALE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_GATE:   gate_q      <= cfg_data[GATE_W-1:0];
				REG_HEIGHT: height_q    <= cfg_data[HEIGHT_W-1:0];
				REG_MINSPD: minspd_q    <= cfg_data[MINSPD_W-1:0];
				REG_STALE:  stale_lim_q <= cfg_data[STALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: accept, difference, square, gate; survivors and frame markers go on
	gsel_front #(
		.COORD_BITS (COORD_BITS),
		.ENTRY_W    (EntryW)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.vel_x         (vel_x),
		.vel_y         (vel_y),
		.vel_z         (vel_z),
		.track_id      (track_id),
		.age           (age),
		.gate_distance (gate_q),
		.height_limit  (height_q),
		.q_stat        (q_stat),
		.q_push        (q_push),
		.q_wdata       (q_wdata)
	);

	// Queue decouples the gate pipeline from the selection logic
	gsel_fifo #(
		.WIDTH (EntryW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	// Back: running bests per frame, choice and output register
	gsel_back #(
		.COORD_BITS (COORD_BITS),
		.ENTRY_W    (EntryW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.min_speed   (minspd_q),
		.stale_limit (stale_lim_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.known       (known),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z),
		.out_id      (out_id),
		.out_age     (out_age),
		.stale       (stale)
	);

endmodule

// ===== sv/gsel_checker.sv =====
// Port-level checks of the gated target selector and their binding.
module gsel_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                known,
	input logic signed [gsel_pkg::POS_W-1:0]   out_x,
	input logic signed [gsel_pkg::POS_W-1:0]   out_y,
	input logic signed [gsel_pkg::POS_W-1:0]   out_z,
	input logic [gsel_pkg::ID_W-1:0]           out_id,
	input logic [gsel_pkg::AGE_W-1:0]          out_age,
	input logic                                stale
);
	import gsel_pkg::*;

	// A stalled result holds its valid, known, id, x and age fields
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(known) && $stable(out_id)
		&& $stable(out_x) && $stable(out_age))
		else $error("result changed while stalled");

	// An empty frame reports all-zero fields
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !known |-> out_x == '0 && out_y == '0 && out_z == '0
		&& out_id == '0 && out_age == '0 && !stale)
		else $error("unknown result carries nonzero fields");

	// Only a chosen candidate can be stale, and then its age is above zero
	a_stale_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stale |-> known && out_age != '0)
		else $error("stale flag without a chosen candidate");

	// No result is present at the first edge after reset
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result present right after reset");

endmodule

bind gated_target_selector_unit gsel_checker u_gsel_checker (.*);
